>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/fjp_pkg.sv
package fjp_pkg;

    localparam int unsigned PKT_SLOTS = 7;

    typedef enum logic [3:0] {
        PH_START      = 4'd0,
        PH_BOM        = 4'd1,
        PH_PRE        = 4'd2,
        PH_OPEN       = 4'd3,
        PH_STR        = 4'd4,
        PH_AFTER_KEY  = 4'd5,
        PH_BEFORE_VAL = 4'd6,
        PH_AFTER_VAL  = 4'd7,
        PH_BEFORE_KEY = 4'd8,
        PH_DONE       = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        ES_NONE    = 3'd0,
        ES_BSLASH  = 3'd1,
        ES_HEX     = 3'd2,
        ES_HELD    = 3'd3,
        ES_HELD_BS = 3'd4,
        ES_LOW_HEX = 3'd5
    } esc_t;

    typedef enum logic [2:0] {
        K_KEY     = 3'd0,
        K_VAL     = 3'd1,
        K_KEY_END = 3'd2,
        K_VAL_END = 3'd3,
        K_OK      = 3'd4,
        K_ERR     = 3'd5
    } kind_t;

    localparam logic [7:0] BOM_0 = 8'hEF;
    localparam logic [7:0] BOM_1 = 8'hBB;
    localparam logic [7:0] BOM_2 = 8'hBF;
    localparam logic [15:0] HI_SUR_LO = 16'hD800;
    localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
    localparam logic [15:0] LO_SUR_LO = 16'hDC00;
    localparam logic [15:0] LO_SUR_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // All results caused by one text item
    typedef struct packed {
        logic [PKT_SLOTS-1:0][7:0] data;
        kind_t [PKT_SLOTS-1:0]     kind;
        logic [2:0]                cnt;
    } pkt_t;

    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] b;
    } utf8_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] v;
    } hex_t;

    typedef struct packed {
        logic       ok;
        logic       is_u;
        logic [7:0] val;
    } escmap_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic hex_t hex_val(input logic [7:0] c);
        hex_t r;
        r = '0;
        if (c >= "0" && c <= "9") begin
            r.ok = 1'b1;
            r.v  = 4'(c - 8'h30);
        end
        else if (c >= "a" && c <= "f") begin
            r.ok = 1'b1;
            r.v  = 4'(c - 8'h57);
        end
        else if (c >= "A" && c <= "F") begin
            r.ok = 1'b1;
            r.v  = 4'(c - 8'h37);
        end
        return r;
    endfunction

    function automatic escmap_t esc_map(input logic [7:0] c);
        escmap_t r;
        r = '{ok: 1'b1, is_u: 1'b0, val: 8'h00};
        case (c)
            8'h22:   r.val = 8'h22;
            8'h5C:   r.val = 8'h5C;
            8'h2F:   r.val = 8'h2F;
            8'h62:   r.val = 8'h08;
            8'h66:   r.val = 8'h0C;
            8'h6E:   r.val = 8'h0A;
            8'h72:   r.val = 8'h0D;
            8'h74:   r.val = 8'h09;
            8'h75:   r.is_u = 1'b1;
            default: r.ok = 1'b0;
        endcase
        return r;
    endfunction

    function automatic utf8_t utf8_enc(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.n    = 3'd1;
            r.b[0] = cp[7:0];
        end
        else if (cp < 21'h800) begin
            r.n    = 3'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000) begin
            r.n    = 3'd3;
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end
        else begin
            r.n    = 3'd4;
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

>>> sv/fjp_front.sv
module fjp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    text_byte,
    input  logic          end_of_text,
    output logic          pkt_valid,
    output fjp_pkg::pkt_t pkt
);
    import fjp_pkg::*;

    phase_t      phase_reg, phase_next;
    esc_t        esc_reg, esc_next;
    logic [1:0]  mc_reg, mc_next;
    logic [1:0]  dc_reg, dc_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] held_reg, held_next;
    logic        rk_reg, rk_next;
    logic        err_reg, err_next;

    logic        bad, a_en, b_en, m_en, f_en, do_plain, do_esc, take;
    logic [20:0] b_cp;
    logic [15:0] take_v, acc_sh;
    kind_t       m_kind, f_kind, d_kind;
    hex_t        hx;
    escmap_t     em;
    utf8_t       enc_a, enc_b;
    logic [2:0]  pos;

    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        mc_next    = mc_reg;
        dc_next    = dc_reg;
        acc_next   = acc_reg;
        held_next  = held_reg;
        rk_next    = rk_reg;
        err_next   = err_reg;
        bad = 1'b0; a_en = 1'b0; b_en = 1'b0; m_en = 1'b0; f_en = 1'b0;
        do_plain = 1'b0; do_esc = 1'b0; take = 1'b0;
        b_cp = '0; take_v = '0;
        m_kind = K_ERR; f_kind = K_ERR;
        hx = hex_val(text_byte);
        em = esc_map(text_byte);
        acc_sh = {acc_reg[11:0], hx.v};

        if (err_reg)
        begin
            f_en = end_of_text;
        end
        else
        begin
            case (phase_reg)
                PH_START, PH_PRE:
                begin
                    if (phase_reg == PH_START && text_byte == BOM_0)
                    begin
                        phase_next = PH_BOM;
                        mc_next    = 2'd1;
                    end
                    else if (is_ws(text_byte))
                        phase_next = PH_PRE;
                    else if (text_byte == "{")
                        phase_next = PH_OPEN;
                    else
                        bad = 1'b1;
                end
                PH_BOM:
                begin
                    if (mc_reg == 2'd1 && text_byte == BOM_1)
                        mc_next = 2'd2;
                    else if (mc_reg == 2'd2 && text_byte == BOM_2)
                    begin
                        mc_next    = 2'd0;
                        phase_next = PH_PRE;
                    end
                    else
                        bad = 1'b1;
                end
                PH_OPEN:
                begin
                    if (text_byte == "}")
                        phase_next = PH_DONE;
                    else if (text_byte == 8'h22)
                    begin
                        phase_next = PH_STR;
                        esc_next   = ES_NONE;
                    end
                    else if (!is_ws(text_byte))
                        bad = 1'b1;
                end
                PH_AFTER_KEY:
                begin
                    if (text_byte == ":")
                        phase_next = PH_BEFORE_VAL;
                    else if (!is_ws(text_byte))
                        bad = 1'b1;
                end
                PH_BEFORE_VAL, PH_BEFORE_KEY:
                begin
                    if (text_byte == 8'h22)
                    begin
                        phase_next = PH_STR;
                        esc_next   = ES_NONE;
                    end
                    else if (!is_ws(text_byte))
                        bad = 1'b1;
                end
                PH_AFTER_VAL:
                begin
                    if (text_byte == ",")
                        phase_next = PH_BEFORE_KEY;
                    else if (text_byte == "}")
                        phase_next = PH_DONE;
                    else if (!is_ws(text_byte))
                        bad = 1'b1;
                end
                PH_DONE:
                    bad = !is_ws(text_byte);
                PH_STR:
                begin
                    case (esc_reg)
                        ES_NONE:    do_plain = 1'b1;
                        ES_BSLASH:  do_esc   = 1'b1;
                        ES_HEX:
                        begin
                            if (!hx.ok)
                                bad = 1'b1;
                            else
                            begin
                                acc_next = acc_sh;
                                if (dc_reg == 2'd3)
                                begin
                                    dc_next = 2'd0;
                                    take    = 1'b1;
                                    take_v  = acc_sh;
                                end
                                else
                                    dc_next = dc_reg + 2'd1;
                            end
                        end
                        ES_HELD:
                        begin
                            if (text_byte == 8'h5C)
                                esc_next = ES_HELD_BS;
                            else
                            begin
                                a_en     = 1'b1;
                                do_plain = 1'b1;
                            end
                        end
                        ES_HELD_BS:
                        begin
                            if (text_byte == "u")
                            begin
                                esc_next = ES_LOW_HEX;
                                dc_next  = 2'd0;
                                acc_next = '0;
                            end
                            else
                            begin
                                a_en   = 1'b1;
                                do_esc = 1'b1;
                            end
                        end
                        ES_LOW_HEX:
                        begin
                            if (!hx.ok)
                                bad = 1'b1;
                            else
                            begin
                                acc_next = acc_sh;
                                if (dc_reg == 2'd3)
                                begin
                                    dc_next = 2'd0;
                                    if (acc_sh >= LO_SUR_LO && acc_sh <= LO_SUR_HI)
                                    begin
                                        // pair combines into a supplementary code point
                                        b_en      = 1'b1;
                                        b_cp      = SUPP_BASE
                                                  + {1'b0, held_reg[9:0], acc_sh[9:0]};
                                        held_next = '0;
                                        esc_next  = ES_NONE;
                                    end
                                    else
                                    begin
                                        a_en   = 1'b1;
                                        take   = 1'b1;
                                        take_v = acc_sh;
                                    end
                                end
                                else
                                    dc_next = dc_reg + 2'd1;
                            end
                        end
                        default:    bad = 1'b1;
                    endcase
                end
                default: bad = 1'b1;
            endcase

            // held high surrogate goes out alone
            if (a_en)
            begin
                held_next = '0;
                esc_next  = ES_NONE;
            end
            if (do_plain)
            begin
                if (text_byte == 8'h22)
                begin
                    m_en       = 1'b1;
                    m_kind     = rk_reg ? K_KEY_END : K_VAL_END;
                    rk_next    = !rk_reg;
                    phase_next = rk_reg ? PH_AFTER_KEY : PH_AFTER_VAL;
                end
                else if (text_byte == 8'h5C)
                    esc_next = ES_BSLASH;
                else
                begin
                    b_en = 1'b1;
                    b_cp = {13'd0, text_byte};
                end
            end
            if (do_esc)
            begin
                esc_next = ES_NONE;
                if (!em.ok)
                    bad = 1'b1;
                else if (em.is_u)
                begin
                    esc_next = ES_HEX;
                    dc_next  = 2'd0;
                    acc_next = '0;
                end
                else
                begin
                    b_en = 1'b1;
                    b_cp = {13'd0, em.val};
                end
            end
            if (take)
            begin
                if (take_v >= HI_SUR_LO && take_v <= HI_SUR_HI)
                begin
                    held_next = take_v;
                    esc_next  = ES_HELD;
                end
                else
                begin
                    b_en     = 1'b1;
                    b_cp     = {5'd0, take_v};
                    esc_next = ES_NONE;
                end
            end
            if (bad)
            begin
                m_en     = 1'b1;
                m_kind   = K_ERR;
                err_next = 1'b1;
            end
            else if (end_of_text)
            begin
                f_en   = 1'b1;
                f_kind = (phase_next == PH_DONE) ? K_OK : K_ERR;
            end
        end

        if (end_of_text)
        begin
            phase_next = PH_START;
            esc_next   = ES_NONE;
            mc_next    = '0;
            dc_next    = '0;
            acc_next   = '0;
            held_next  = '0;
            rk_next    = 1'b1;
            err_next   = 1'b0;
        end
    end

    // pack results: held flush, code point, marker, final status
    always_comb
    begin
        enc_a  = utf8_enc({5'd0, held_reg});
        enc_b  = utf8_enc(b_cp);
        d_kind = rk_reg ? K_KEY : K_VAL;
        pkt    = '0;
        pos    = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (a_en && 3'(i) < enc_a.n)
            begin
                pkt.data[pos] = enc_a.b[i];
                pkt.kind[pos] = d_kind;
                pos = pos + 3'd1;
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            if (b_en && 3'(i) < enc_b.n)
            begin
                pkt.data[pos] = enc_b.b[i];
                pkt.kind[pos] = d_kind;
                pos = pos + 3'd1;
            end
        end
        if (m_en)
        begin
            pkt.kind[pos] = m_kind;
            pos = pos + 3'd1;
        end
        if (f_en)
        begin
            pkt.kind[pos] = f_kind;
            pos = pos + 3'd1;
        end
        pkt.cnt   = pos;
        pkt_valid = accept && (pos != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            esc_reg   <= ES_NONE;
            mc_reg    <= '0;
            dc_reg    <= '0;
            acc_reg   <= '0;
            held_reg  <= '0;
            rk_reg    <= 1'b1;
            err_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            mc_reg    <= mc_next;
            dc_reg    <= dc_next;
            acc_reg   <= acc_next;
            held_reg  <= held_next;
            rk_reg    <= rk_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> sv/fjp_queue.sv
module fjp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  fjp_pkg::pkt_t wr_pkt,
    input  logic          rd_en,
    output fjp_pkg::pkt_t head,
    output logic          full,
    output logic          empty,
    output logic [1:0]    count
);
    import fjp_pkg::*;

    pkt_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign head  = q_reg[rp_reg];
    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign count = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_reg[wp_reg] <= wr_pkt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= !wp_reg;
            if (rd_en)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule

>>> sv/fjp_back.sv
module fjp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  fjp_pkg::pkt_t head,
    input  logic          q_empty,
    input  logic          pop,
    output logic          q_pop,
    output logic [2:0]    idx,
    output logic          empty,
    output logic [7:0]    data_byte,
    output logic [2:0]    kind,
    output logic          last_of_run
);
    import fjp_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       take;

    assign empty       = q_empty;
    assign data_byte   = head.data[idx_reg];
    assign kind        = head.kind[idx_reg];
    assign last_of_run = (idx_reg == head.cnt - 3'd1);
    assign take        = pop && !q_empty;
    assign q_pop       = take && last_of_run;
    assign idx_next    = q_pop ? 3'd0 : idx_reg + 3'd1;
    assign idx         = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (take)
            idx_reg <= idx_next;
    end

endmodule

>>> sv/flat_json_object_parser.sv
// Channel  | Handshake        | Fields
// ---------+------------------+-------------------------------
// text in  | push / full      | text_byte[7:0], end_of_text
// results  | pop / empty      | data_byte[7:0], kind[2:0], last_of_run
//
// One text item is taken per cycle while the result queue has room.
// An item gives 0 to 7 results; they leave one per cycle while pop is high,
// so an item's results hold the output side until all are popped (UTF-8 runs, flushes).
// A two-entry queue of per-item result groups parts parser and output.
// rst_n is asynchronous; reset leaves the parser at start of text.
`include "assert_macros.svh"

module flat_json_object_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] data_byte,
    output logic [2:0] kind,
    output logic       last_of_run
);
    import fjp_pkg::*;

    logic       accept;
    logic       pkt_valid;
    pkt_t       pkt;
    pkt_t       head;
    logic       q_empty;
    logic       q_pop;
    logic [1:0] q_count;
    logic [2:0] idx;

    // Front: parses each accepted item into a group of results
    assign accept = push && !full;

    fjp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .pkt_valid   (pkt_valid),
        .pkt         (pkt)
    );

    // Queue of result groups; items with no results never enter it
    fjp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (pkt_valid),
        .wr_pkt (pkt),
        .rd_en  (q_pop),
        .head   (head),
        .full   (full),
        .empty  (q_empty),
        .count  (q_count)
    );

    // Back: walks the head group one result per pop
    fjp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .q_pop       (q_pop),
        .idx         (idx),
        .empty       (empty),
        .data_byte   (data_byte),
        .kind        (kind),
        .last_of_run (last_of_run)
    );

    `ASSERT_SAME(a_head_in_range, clk, rst_n, !q_empty, (head.cnt != 3'd0) && (idx < head.cnt))
    `ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, q_count <= 2'd2)
    `ASSERT_NEXT(a_drain_empty, clk, rst_n, q_pop && (q_count == 2'd1) && !pkt_valid, empty)
    `ASSERT_SAME(a_idle_idx, clk, rst_n, q_empty, idx == 3'd0)

endmodule
